// ===== rtl/core/connection_greylist_table_core_assert.svh =====
// Assertion macros shared by the greylisting table RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef CONNECTION_GREYLIST_TABLE_CORE_ASSERT_SVH
`define CONNECTION_GREYLIST_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define GCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define GCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gct_pkg.sv =====
// Types and constants of the connection greylisting table.
// No dependencies; imported by every module of the block.
`default_nettype none

package gct_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DEADLINE_W = 33;
  localparam int unsigned CFG_TIME_W = 24;
  localparam int unsigned REMOVED_W  = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_TIME_W-1:0] HOLD_TIME_RESET  = 24'd5000;
  localparam logic [CFG_TIME_W-1:0] CLEAN_TIME_RESET = 24'd30000;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAN_TIME = 2'd2;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_SWEEP   = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] address;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic                 admit;
    logic                 table_full;
    logic [REMOVED_W-1:0] removed_count;
  } out_item_t;

  typedef struct packed {
    logic                  valid;
    logic [ADDR_W-1:0]     address;
    logic [DEADLINE_W-1:0] deadline;
  } entry_t;

  typedef struct packed {
    logic [DEADLINE_W-1:0] base;
    logic [CFG_TIME_W-1:0] offset;
    logic [TIME_W-1:0]     limit;
  } alu_in_t;

  typedef struct packed {
    logic [DEADLINE_W:0] sum;
    logic                below;
  } alu_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/gct_table_mem.sv =====
// Entry store of the greylisting table: one write and one registered read a cycle.
// Depends on gct_pkg for the entry type.
`default_nettype none

module gct_table_mem #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned IDX_W   = 6
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire gct_pkg::entry_t   wr_data,
  input  wire logic              rd_en,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output gct_pkg::entry_t        rd_data
);
  import gct_pkg::*;

  entry_t mem_r [ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/gct_cmp_unit.sv =====
// Shared add-and-compare unit: forms base + offset one bit wider than base and tests it below limit.
// Depends on gct_pkg for the operand and result structs.
`default_nettype none

module gct_cmp_unit (
  input  wire gct_pkg::alu_in_t  op_in,
  output gct_pkg::alu_out_t      op_out
);
  import gct_pkg::*;

  always_comb begin
    op_out.sum   = {1'b0, op_in.base} + {{(DEADLINE_W + 1 - CFG_TIME_W){1'b0}}, op_in.offset};
    op_out.below = op_out.sum < {{(DEADLINE_W + 1 - TIME_W){1'b0}}, op_in.limit};
  end

endmodule

`default_nettype wire

// ===== rtl/core/connection_greylist_table_core.sv =====
// Top level of the connection greylisting table: sequencer, configuration registers
// and output register. Depends on gct_pkg, gct_table_mem, gct_cmp_unit and the assert header.
`default_nettype none

// The block keeps a table of ENTRIES source addresses, each with a 33-bit deadline,
// in a single-port-write, single-port-read memory. Every table access walks the
// memory one entry per cycle, and one shared add-and-compare unit evaluates each
// entry as it comes out of the registered read port. A connection request with
// greylisting enabled walks the whole table when the table is full, walks it and
// then stores the address in a free slot when the address is new and a slot is
// free, and stops the walk at the match when the address is found. A cleanup
// sweep always walks the whole table. A request with greylisting disabled does
// not touch the table. The input side stalls while a transfer is being worked on
// and accepts the next transfer as soon as the result has moved to the output
// register, which holds it until the downstream side takes the transfer. After
// reset the block first clears the valid bit of every entry, one per cycle, and
// stalls the input meanwhile; configuration writes are taken at any time.
// Register 0 is enable, register 1 is hold_time and register 2 is clean_time;
// writes to index 3 are dropped.
module connection_greylist_table_core #(
  parameter int unsigned ENTRIES = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire gct_pkg::in_item_t                   in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output gct_pkg::out_item_t                       out_data,
  input  wire logic                                cfg_wr_en,
  input  wire logic [gct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gct_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import gct_pkg::*;

`include "connection_greylist_table_core_assert.svh"

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_INSERT = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  in_item_t          item_r, item_nxt;
  logic              have_free_r, have_free_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]  rm_cnt_r, rm_cnt_nxt;
  out_item_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic                  enable_r;
  logic [CFG_TIME_W-1:0] hold_time_r;
  logic [CFG_TIME_W-1:0] clean_time_r;

  logic              in_fire;
  logic              last_entry;
  logic              have_free_now;

  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  entry_t            mem_wr_data;
  logic              mem_rd_en;
  logic [IDX_W-1:0]  mem_rd_addr;
  entry_t            mem_rd_data;

  alu_in_t           alu_in;
  alu_out_t          alu_out;

  gct_table_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  gct_cmp_unit u_cmp (
    .op_in  (alu_in),
    .op_out (alu_out)
  );

  // The block takes a transfer only when it is idle; nothing else gates it.
  assign in_stall   = (state_r != ST_IDLE);
  assign in_fire    = in_valid && (state_r == ST_IDLE);
  assign last_entry = (idx_r == LAST_IDX);

  // A slot is free for a new address if an earlier one was, or this one is.
  assign have_free_now = have_free_r || !mem_rd_data.valid;

  // The shared unit serves three jobs. In a sweep it tests deadline + clean_time
  // against now, in a request it tests the deadline alone against now, and while
  // inserting it forms now + hold_time as the new deadline.
  always_comb begin
    alu_in.limit = item_r.now_ms;
    if (state_r == ST_INSERT) begin
      alu_in.base   = {1'b0, item_r.now_ms};
      alu_in.offset = hold_time_r;
    end else begin
      alu_in.base   = mem_rd_data.deadline;
      alu_in.offset = (item_r.operation == OP_SWEEP) ? clean_time_r : '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    item_nxt      = item_r;
    have_free_nxt = have_free_r;
    free_idx_nxt  = free_idx_r;
    rm_cnt_nxt    = rm_cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_r;
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = IDX_W'(idx_r + 1'b1);

    // The downstream side frees the output register when it takes the transfer.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        // Reset pass: mark every entry empty, one per cycle.
        mem_wr_en         = 1'b1;
        mem_wr_data       = '0;
        idx_nxt           = IDX_W'(idx_r + 1'b1);
        if (last_entry) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          item_nxt      = in_data;
          idx_nxt       = '0;
          have_free_nxt = 1'b0;
          free_idx_nxt  = '0;
          rm_cnt_nxt    = '0;
          if (in_data.operation == OP_REQUEST && !enable_r) begin
            // Greylisting is off: admit at once and leave the table alone.
            res_nxt   = '{admit: 1'b1, table_full: 1'b0, removed_count: '0};
            state_nxt = ST_DONE;
          end else begin
            // Start the walk by reading entry zero.
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            state_nxt   = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // The read data belongs to entry idx_r; fetch the next entry meanwhile.
        mem_rd_en = !last_entry;
        idx_nxt   = IDX_W'(idx_r + 1'b1);
        if (item_r.operation == OP_SWEEP) begin
          if (mem_rd_data.valid && alu_out.below) begin
            mem_wr_en         = 1'b1;
            mem_wr_data.valid = 1'b0;
            rm_cnt_nxt        = CNT_W'(rm_cnt_r + 1'b1);
          end
          if (last_entry) begin
            res_nxt   = '{admit: 1'b0, table_full: 1'b0,
                          removed_count: REMOVED_W'(rm_cnt_nxt)};
            state_nxt = ST_DONE;
          end
        end else begin
          if (!have_free_r && !mem_rd_data.valid) begin
            have_free_nxt = 1'b1;
            free_idx_nxt  = idx_r;
          end
          if (mem_rd_data.valid && mem_rd_data.address == item_r.address) begin
            // Known address: admit only once its deadline has passed.
            mem_rd_en = 1'b0;
            res_nxt   = '{admit: alu_out.below, table_full: 1'b0, removed_count: '0};
            state_nxt = ST_DONE;
          end else if (last_entry) begin
            if (have_free_now) begin
              state_nxt = ST_INSERT;
            end else begin
              res_nxt   = '{admit: 1'b0, table_full: 1'b1, removed_count: '0};
              state_nxt = ST_DONE;
            end
          end
        end
      end

      ST_INSERT: begin
        // New address goes into the lowest free slot and is refused this time.
        mem_wr_en   = 1'b1;
        mem_wr_addr = free_idx_r;
        mem_wr_data = '{valid: 1'b1, address: item_r.address,
                        deadline: alu_out.sum[DEADLINE_W-1:0]};
        res_nxt     = '{admit: 1'b0, table_full: 1'b0, removed_count: '0};
        state_nxt   = ST_DONE;
      end

      ST_DONE: begin
        // Hand the result over as soon as the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
        idx_nxt   = '0;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      enable_r     <= 1'b0;
      hold_time_r  <= HOLD_TIME_RESET;
      clean_time_r <= CLEAN_TIME_RESET;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ENABLE:     enable_r     <= cfg_data[0];
          CFG_HOLD_TIME:  hold_time_r  <= cfg_data[CFG_TIME_W-1:0];
          CFG_CLEAN_TIME: clean_time_r <= cfg_data[CFG_TIME_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers: every one is loaded before it is read, so no reset.
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    have_free_r <= have_free_nxt;
    free_idx_r  <= free_idx_nxt;
    rm_cnt_r    <= rm_cnt_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A sweep never admits or flags a full table, so a nonzero count stands alone.
  `GCT_ASSERT_NOW(a_sweep_result_clean, out_valid_r && out_data_r.removed_count != '0, !out_data_r.admit && !out_data_r.table_full, "sweep result carries request flags")
  // A full table always means the request was refused.
  `GCT_ASSERT_NOW(a_full_refused, out_valid_r && out_data_r.table_full, !out_data_r.admit, "table_full result was admitted")
  // An accepted transfer makes the block busy in the next cycle.
  `GCT_ASSERT_NEXT(a_busy_after_accept, in_fire, state_r != ST_IDLE, "block idle right after input transfer")
  // A result appears only when the sequencer hands one over.
  `GCT_ASSERT_NOW(a_result_from_done, $rose(out_valid_r), $past(state_r == ST_DONE), "result appeared outside the hand-over state")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for connection_greylist_table_core: admission requests and
// cleanup sweeps are checked against an in-bench table predictor. Depends on gct_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
  import gct_pkg::*;

  localparam int unsigned ENTRIES     = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned POOL_MAX    = 96;
  localparam int unsigned HOLD_OFF    = 400;

  // The block drops writes to the one index that names no register.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: the configuration registers and a copy of the address table.
  bit                    gl_enable = 1'b0;
  bit [CFG_TIME_W-1:0]   gl_hold   = HOLD_TIME_RESET;
  bit [CFG_TIME_W-1:0]   gl_clean  = CLEAN_TIME_RESET;
  bit                    slot_used     [ENTRIES];
  bit [ADDR_W-1:0]       slot_addr     [ENTRIES];
  bit [DEADLINE_W-1:0]   slot_deadline [ENTRIES];

  // Verdicts predicted at input transfer, waiting for their output transfer.
  out_item_t             pending_verdicts[$];
  out_item_t             oldest_verdict;
  int unsigned           mismatch_count = 0;
  int unsigned           cycle_count    = 0;

  // Shared stimulus state: a wall clock that mostly moves forward and a pool of
  // source addresses so that the same addresses come back and hit the table.
  bit [TIME_W-1:0]       wall_ms;
  bit [ADDR_W-1:0]       addr_pool[POOL_MAX];

  // With calm_mode set neither side idles. A nonzero hold_off_request makes the
  // receiver stall without a break for a stretch whose length it gives.
  bit                    calm_mode        = 1'b0;
  int unsigned           hold_off_request = 0;

  connection_greylist_table_core #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Run-away guard. The slowest legal run is well below this count of cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d verdicts outstanding", $time,
               pending_verdicts.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Works out the verdict of one accepted transfer and updates the table copy.
  // Sums are formed wider than their operands so that they never wrap.
  function automatic out_item_t predict_verdict(input in_item_t item);
    out_item_t           verdict;
    bit [DEADLINE_W:0]   expiry;
    bit [REMOVED_W-1:0]  dropped;
    int                  free_slot;
    int                  slot;
    verdict   = '0;
    dropped   = '0;
    free_slot = -1;
    if (item.operation == OP_SWEEP) begin
      for (slot = 0; slot < ENTRIES; slot++) begin
        if (slot_used[slot]) begin
          expiry = {1'b0, slot_deadline[slot]} + gl_clean;
          if (expiry < {2'b00, item.now_ms}) begin
            slot_used[slot] = 1'b0;
            dropped++;
          end
        end
      end
      verdict.removed_count = dropped;
    end else if (!gl_enable) begin
      verdict.admit = 1'b1;
    end else begin
      for (slot = 0; slot < ENTRIES; slot++) begin
        if (slot_used[slot]) begin
          if (slot_addr[slot] == item.address) begin
            verdict.admit = ({1'b0, item.now_ms} > slot_deadline[slot]);
            return verdict;
          end
        end else if (free_slot < 0) begin
          free_slot = slot;
        end
      end
      if (free_slot < 0) begin
        verdict.table_full = 1'b1;
      end else begin
        slot_used[free_slot]     = 1'b1;
        slot_addr[free_slot]     = item.address;
        slot_deadline[free_slot] = {1'b0, item.now_ms} + gl_hold;
      end
    end
    return verdict;
  endfunction

  function automatic in_item_t request_item(input bit [ADDR_W-1:0] addr,
                                            input bit [TIME_W-1:0] now);
    in_item_t item;
    item.operation = OP_REQUEST;
    item.address   = addr;
    item.now_ms    = now;
    return item;
  endfunction

  // The address of a sweep is ignored by the block, so it carries random bits.
  function automatic in_item_t sweep_item(input bit [TIME_W-1:0] now);
    in_item_t item;
    item.operation = OP_SWEEP;
    item.address   = $urandom;
    item.now_ms    = now;
    return item;
  endfunction

  // Random traffic: mostly requests from the address pool at a forward-moving time,
  // some fresh addresses, some sweeps, and now and then a time out of order.
  function automatic in_item_t make_item(input int unsigned pool_size,
                                         input int unsigned step_max,
                                         input int unsigned sweep_pct);
    in_item_t    item;
    int unsigned roll;
    roll           = $urandom_range(99);
    wall_ms        = wall_ms + $urandom_range(step_max);
    item.operation = OP_REQUEST;
    item.address   = $urandom;
    item.now_ms    = wall_ms;
    if (roll < sweep_pct) begin
      item.operation = OP_SWEEP;
    end else if (roll < 92) begin
      item.address = addr_pool[$urandom_range(pool_size - 1)];
    end
    if ($urandom_range(99) < 3) begin
      item.now_ms = $urandom;
    end
    return item;
  endfunction

  // Offers one item and returns at the rising edge of its transfer. Valid is left
  // high; the next call either replaces the payload or lowers valid at the next
  // falling edge, so every change is a single assignment in its time step.
  task automatic send_item(input in_item_t item);
    while (!calm_mode && $urandom_range(99) < 18) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_verdicts.push_back(predict_verdict(item));
  endtask

  // Stops offering, waits for every predicted verdict to arrive, then lets the
  // block settle for longer than its slowest table walk.
  task automatic wait_until_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_ENABLE:     gl_enable = value[0];
      CFG_HOLD_TIME:  gl_hold   = value;
      CFG_CLEAN_TIME: gl_clean  = value;
      default: ;
    endcase
  endtask

  // Writes all three registers once the block is idle. The enable write carries
  // random upper bits, which the block must ignore.
  task automatic set_config(input logic en, input logic [CFG_TIME_W-1:0] hold_ms,
                            input logic [CFG_TIME_W-1:0] clean_ms);
    wait_until_idle();
    write_reg(CFG_ENABLE, {23'($urandom), en});
    write_reg(CFG_HOLD_TIME, hold_ms);
    write_reg(CFG_CLEAN_TIME, clean_ms);
  endtask

  task automatic run_random_phase(input int unsigned count, input logic en,
                                  input logic [CFG_TIME_W-1:0] hold_ms,
                                  input logic [CFG_TIME_W-1:0] clean_ms,
                                  input int unsigned step_max,
                                  input int unsigned pool_size,
                                  input int unsigned sweep_pct);
    set_config(en, hold_ms, clean_ms);
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    repeat (count) send_item(make_item(pool_size, step_max, sweep_pct));
  endtask

  task automatic compare_field(input string field, input logic [REMOVED_W-1:0] expected,
                               input logic [REMOVED_W-1:0] actual);
    if (actual !== expected) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected,
               actual);
    end
  endtask

  // Every output transfer is matched against the oldest verdict still waiting.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        compare_field("admit", REMOVED_W'(oldest_verdict.admit),
                      REMOVED_W'(out_data.admit));
        compare_field("table_full", REMOVED_W'(oldest_verdict.table_full),
                      REMOVED_W'(out_data.table_full));
        compare_field("removed_count", oldest_verdict.removed_count,
                      out_data.removed_count);
      end
    end
  end

  // The receiver stalls at random, not at all in calm mode, and for a long
  // unbroken stretch when a test asks for one. The stretch is counted here.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request != 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm_mode) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 18);
      end
    end
  end

  // Straight out of reset greylisting is off, so every request is admitted and a
  // sweep over the empty table drops nothing.
  task automatic test_disabled_defaults();
    send_item(request_item(32'h0000_0000, 32'h0000_0000));
    send_item(request_item(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(sweep_item(32'hFFFF_FFFF));
  endtask

  // With the reset hold and clean times: a new address is refused, stays refused
  // up to and including its deadline, and is admitted one millisecond later.
  // Sweeps drop an entry only once its deadline plus the clean time has passed.
  // A write to the unused index in between must change nothing.
  task automatic test_admission_window();
    wait_until_idle();
    write_reg(CFG_ENABLE, 24'h00_0001);
    write_reg(CFG_UNUSED, 24'h00_0000);
    send_item(request_item(32'h0A00_0001, 32'd1000));
    send_item(request_item(32'h0A00_0001, 32'd6000));
    send_item(request_item(32'h0A00_0001, 32'd6001));
    send_item(request_item(32'h0000_0000, 32'd6001));
    send_item(sweep_item(32'd36001));
    send_item(sweep_item(32'd41002));
  endtask

  // Only bit 0 of the enable write counts. Then zero hold and clean times, where
  // the boundaries sit exactly on the stored time, and a sweep while disabled.
  task automatic test_zero_windows_and_masking();
    wait_until_idle();
    write_reg(CFG_ENABLE, 24'hFF_FFFE);
    send_item(request_item(32'h0A00_0001, 32'd50000));
    set_config(1'b1, 24'd0, 24'd0);
    send_item(request_item(32'h0A00_0001, 32'd50000));
    send_item(request_item(32'h0A00_0001, 32'd50001));
    send_item(sweep_item(32'd50000));
    send_item(sweep_item(32'd50001));
    send_item(request_item(32'h0B00_0002, 32'd60000));
    wait_until_idle();
    write_reg(CFG_ENABLE, 24'h00_0000);
    send_item(sweep_item(32'd60001));
  endtask

  // Largest times: the deadline needs its 33rd bit, and so does the sweep sum.
  task automatic test_time_extremes();
    set_config(1'b1, 24'hFF_FFFF, 24'hFF_FFFF);
    send_item(request_item(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(request_item(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(sweep_item(32'hFFFF_FFFF));
    send_item(request_item(32'h0000_0000, 32'h0000_0000));
  endtask

  // Short hold and clean windows and small time steps, so that addresses move
  // through refused, admitted and swept while they keep coming back.
  task automatic test_short_windows();
    wall_ms = $urandom_range(1000);
    run_random_phase(300, 1'b1, CFG_TIME_W'($urandom_range(40)),
                     CFG_TIME_W'($urandom_range(60)), 8, 40, 8);
    wall_ms = wall_ms + 1000;
    run_random_phase(300, 1'b1, 24'd0, 24'd0, 2, 24, 10);
  endtask

  // More distinct addresses than slots and a clean time that keeps entries for
  // good, so the table fills and new addresses are flagged. A late sweep with a
  // zero clean time then empties it again and a few requests refill it.
  task automatic test_table_full();
    run_random_phase(200, 1'b1, CFG_TIME_W'($urandom_range(2000)), 24'hFF_FFFF, 5,
                     POOL_MAX, 2);
    set_config(1'b1, 24'd500, 24'd0);
    wall_ms = wall_ms + 32'd100000;
    send_item(sweep_item(wall_ms));
    repeat (10) send_item(make_item(POOL_MAX, 300, 0));
  endtask

  // Reset-value times at second-scale steps, with neither side ever idling.
  task automatic test_default_windows_back_to_back();
    calm_mode = 1'b1;
    run_random_phase(250, 1'b1, HOLD_TIME_RESET, CLEAN_TIME_RESET, 3000, 32, 10);
    wait_until_idle();
    calm_mode = 1'b0;
  endtask

  // Greylisting off: requests are all admitted, sweeps still clear old entries.
  task automatic test_disabled_traffic();
    run_random_phase(120, 1'b0, CFG_TIME_W'($urandom_range(50)),
                     CFG_TIME_W'($urandom_range(50)), 50, 32, 15);
  endtask

  // Random register values across the whole range, from random starting times,
  // with time steps scaled to the hold time so admissions still happen.
  task automatic test_random_settings();
    logic [CFG_TIME_W-1:0] hold_ms;
    logic [CFG_TIME_W-1:0] clean_ms;
    repeat (3) begin
      hold_ms  = CFG_TIME_W'($urandom_range(24'hFF_FFFF));
      clean_ms = CFG_TIME_W'($urandom_range(24'hFF_FFFF));
      wall_ms  = $urandom;
      run_random_phase(120, 1'b1, hold_ms, clean_ms, (hold_ms >> 3) + 1, 32, 10);
    end
  endtask

  // The receiver holds off for a long stretch while items keep being offered, so
  // the output register stays full and the block stalls its input. The sender
  // then waits until every verdict has come back.
  task automatic test_backpressure();
    set_config(1'b1, 24'd20, 24'd100);
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    hold_off_request = HOLD_OFF;
    repeat (12) send_item(make_item(16, 10, 10));
    wait_until_idle();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_ENABLE;
    cfg_data  = '0;
    wall_ms   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_disabled_defaults();
    test_admission_window();
    test_zero_windows_and_masking();
    test_time_extremes();
    test_short_windows();
    test_table_full();
    test_default_windows_back_to_back();
    test_disabled_traffic();
    test_random_settings();
    test_backpressure();

    // All verdicts are in once this returns; any late extra result is caught by
    // the checker during the settling cycles.
    wait_until_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
